@@ rtl/md5d_pkg.sv @@
// Package with shared types, constants and round functions of the MD5 digest core.
package md5d_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] TAIL_LIMIT = 6'd56;
	localparam logic [3:0] LEN_LO_WORD = 4'd14;
	localparam logic [3:0] LEN_HI_WORD = 4'd15;

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [0:15] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} md5d_in_t;

	typedef struct packed {
		logic [63:0] digest_part;
		logic        part_index;
		logic        last_part;
	} md5d_out_t;

	// Write port into the block word memory.
	typedef struct packed {
		logic        en;
		logic [3:0]  addr;
		logic [31:0] data;
	} md5d_wr_t;

	// Start of one compression and how the block words are to be read.
	typedef struct packed {
		logic       start;
		logic       pad_en;
		logic       len_en;
		logic       zero_all;
		logic [3:0] pad_word;
	} md5d_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] chain_a;
		logic [31:0] chain_b;
		logic [31:0] chain_c;
		logic [31:0] chain_d;
	} md5d_stat_t;

	typedef enum logic [2:0] {
		S_ABSORB,
		S_WAIT_BLK,
		S_FIN_A,
		S_FIN_B,
		S_EMIT
	} md5d_top_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_LOAD,
		C_RUN,
		C_FOLD
	} md5d_cmp_state_t;

	function automatic logic [3:0] md5d_msg_index(input logic [5:0] r);
		logic [3:0] idx;
		idx = '0;
		case (r[5:4])
			2'd0: idx = r[3:0];
			2'd1: idx = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: idx = 4'(r[3:0] * 4'd3 + 4'd5);
			default: idx = 4'(r[3:0] * 4'd7);
		endcase
		return idx;
	endfunction

	function automatic logic [31:0] md5d_round_f(input logic [1:0] phase,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		f = '0;
		case (phase)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

endpackage

@@ rtl/md5d_compress.sv @@
// Block word memory and the 64-round MD5 compression unit with its chaining words.
module md5d_compress (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md5d_pkg::md5d_wr_t    wr,
	input  md5d_pkg::md5d_cmd_t   cmd,
	input  logic                  chain_rst,
	input  logic [63:0]           bit_len,
	output md5d_pkg::md5d_stat_t  stat
);

	logic [31:0] mem [0:15];
	logic [31:0] rd_data_s1;
	logic [3:0]  rd_addr;

	md5d_pkg::md5d_cmp_state_t state_q, state_d;
	md5d_pkg::md5d_cmd_t       cmd_q;
	logic [5:0]  rnd_q;
	logic        done_q;
	logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;

	logic [3:0]  g_cur;
	logic [31:0] m_word;
	logic [31:0] sum;
	logic [63:0] rot_wide;
	logic [31:0] new_b;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// The word for the next round is fetched ahead of it, through the registered memory read.
	assign rd_addr = (state_q == md5d_pkg::C_LOAD) ? md5d_pkg::md5d_msg_index(6'd0)
		: md5d_pkg::md5d_msg_index(rnd_q + 6'd1);

	assign g_cur = md5d_pkg::md5d_msg_index(rnd_q);

	// Padding words come from the length counter or read as zero.
	always_comb begin
		m_word = rd_data_s1;
		if (cmd_q.zero_all || (cmd_q.pad_en && (g_cur > cmd_q.pad_word))) begin
			if (cmd_q.len_en && (g_cur == md5d_pkg::LEN_LO_WORD)) begin
				m_word = bit_len[31:0];
			end else if (cmd_q.len_en && (g_cur == md5d_pkg::LEN_HI_WORD)) begin
				m_word = bit_len[63:32];
			end else begin
				m_word = '0;
			end
		end
	end

	assign sum = wa_q + md5d_pkg::md5d_round_f(rnd_q[5:4], wb_q, wc_q, wd_q)
		+ md5d_pkg::ROUND_K[rnd_q] + m_word;
	assign rot_wide = {sum, sum} << md5d_pkg::ROT_AMT[{rnd_q[5:4], rnd_q[1:0]}];
	assign new_b = wb_q + rot_wide[63:32];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			md5d_pkg::C_IDLE: begin
				if (cmd.start) begin
					state_d = md5d_pkg::C_LOAD;
				end
			end
			md5d_pkg::C_LOAD: state_d = md5d_pkg::C_RUN;
			md5d_pkg::C_RUN: begin
				if (rnd_q == 6'd63) begin
					state_d = md5d_pkg::C_FOLD;
				end
			end
			md5d_pkg::C_FOLD: state_d = md5d_pkg::C_IDLE;
			default: state_d = md5d_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5d_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q  <= '0;
			rnd_q  <= '0;
			done_q <= 1'b0;
			ch_a_q <= md5d_pkg::IV_A;
			ch_b_q <= md5d_pkg::IV_B;
			ch_c_q <= md5d_pkg::IV_C;
			ch_d_q <= md5d_pkg::IV_D;
		end else begin
			done_q <= (state_q == md5d_pkg::C_FOLD);
			if (state_q == md5d_pkg::C_IDLE && cmd.start) begin
				cmd_q <= cmd;
			end
			if (state_q == md5d_pkg::C_LOAD) begin
				rnd_q <= '0;
			end else if (state_q == md5d_pkg::C_RUN) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == md5d_pkg::C_FOLD) begin
				ch_a_q <= ch_a_q + wa_q;
				ch_b_q <= ch_b_q + wb_q;
				ch_c_q <= ch_c_q + wc_q;
				ch_d_q <= ch_d_q + wd_q;
			end else if (chain_rst) begin
				ch_a_q <= md5d_pkg::IV_A;
				ch_b_q <= md5d_pkg::IV_B;
				ch_c_q <= md5d_pkg::IV_C;
				ch_d_q <= md5d_pkg::IV_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == md5d_pkg::C_LOAD) begin
			wa_q <= ch_a_q;
			wb_q <= ch_b_q;
			wc_q <= ch_c_q;
			wd_q <= ch_d_q;
		end else if (state_q == md5d_pkg::C_RUN) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= new_b;
		end
	end

	assign stat.done    = done_q;
	assign stat.chain_a = ch_a_q;
	assign stat.chain_b = ch_b_q;
	assign stat.chain_c = ch_c_q;
	assign stat.chain_d = ch_d_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == md5d_pkg::C_IDLE)
		else $error("compression started while busy");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == md5d_pkg::C_IDLE)
		else $error("block word written during compression");
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == md5d_pkg::C_RUN && rnd_q == 6'd63) |=> ##1 done_q)
		else $error("compression did not finish after the last round");
`endif

endmodule

@@ rtl/md5_message_digest_core.sv @@
// Top level of the MD5 digest core: byte packing, length count, padding control and digest output.
//
//  channel | direction | beat                               | handshake
//  msg     | in        | kind, data_byte: one byte or finish | msg_valid / msg_stall
//  dig     | out       | digest_part, part_index, last_part | dig_valid / dig_stall
//
// Message bytes are taken one per cycle while msg_stall is low; the 64th byte of a block
// starts a compression (a load, 64 rounds, a fold) and msg_stall stays high until it is done.
// A finish beat holds msg_stall high until the digest is registered, after a second compression
// when 56 or more bytes are pending; longer while an earlier digest is undrained.
// Bytes are taken again while the two digest beats drain.
// After reset the chaining words hold the standard initial values and the length is zero.
module md5_message_digest_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  md5d_pkg::md5d_in_t  msg,
	output logic                dig_valid,
	input  logic                dig_stall,
	output md5d_pkg::md5d_out_t dig
);

	md5d_pkg::md5d_top_state_t state_q, state_d;
	md5d_pkg::md5d_wr_t   wr;
	md5d_pkg::md5d_cmd_t  cmd;
	md5d_pkg::md5d_stat_t stat;

	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [31:0]  word_q;
	logic         two_blk_q;
	logic         out_valid_q;
	logic         part_q;
	logic [127:0] digest_q;

	logic         accept;
	logic         capture;
	logic         chain_rst;
	logic [7:0]   byte_v;
	logic [31:0]  shifted;
	logic [31:0]  merged;

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	md5d_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd       (cmd),
		.chain_rst (chain_rst),
		.bit_len   (len_q),
		.stat      (stat)
	);

	assign accept  = msg_valid && !msg_stall;
	assign byte_v  = (msg.kind == md5d_pkg::KIND_FINISH) ? md5d_pkg::PAD_BYTE : msg.data_byte;
	assign shifted = {24'b0, byte_v} << {fill_q[1:0], 3'b000};
	// The first byte of a word clears the rest of it.
	assign merged  = (fill_q[1:0] == 2'd0) ? shifted : (word_q | shifted);

	always_comb begin
		state_d   = state_q;
		msg_stall = 1'b1;
		wr        = '0;
		cmd       = '0;
		capture   = 1'b0;
		chain_rst = 1'b0;
		unique case (state_q)
			md5d_pkg::S_ABSORB: begin
				msg_stall = 1'b0;
				if (msg_valid) begin
					wr.en   = 1'b1;
					wr.addr = fill_q[5:2];
					wr.data = merged;
					if (msg.kind == md5d_pkg::KIND_FINISH) begin
						cmd.start    = 1'b1;
						cmd.pad_en   = 1'b1;
						cmd.len_en   = (fill_q < md5d_pkg::TAIL_LIMIT);
						cmd.pad_word = fill_q[5:2];
						state_d      = md5d_pkg::S_FIN_A;
					end else if (fill_q == 6'd63) begin
						cmd.start = 1'b1;
						state_d   = md5d_pkg::S_WAIT_BLK;
					end
				end
			end
			md5d_pkg::S_WAIT_BLK: begin
				if (stat.done) begin
					state_d = md5d_pkg::S_ABSORB;
				end
			end
			md5d_pkg::S_FIN_A: begin
				if (stat.done) begin
					if (two_blk_q) begin
						// Extra block of zeros that carries only the length.
						cmd.start    = 1'b1;
						cmd.zero_all = 1'b1;
						cmd.len_en   = 1'b1;
						state_d      = md5d_pkg::S_FIN_B;
					end else begin
						state_d = md5d_pkg::S_EMIT;
					end
				end
			end
			md5d_pkg::S_FIN_B: begin
				if (stat.done) begin
					state_d = md5d_pkg::S_EMIT;
				end
			end
			md5d_pkg::S_EMIT: begin
				if (!out_valid_q) begin
					capture   = 1'b1;
					chain_rst = 1'b1;
					state_d   = md5d_pkg::S_ABSORB;
				end
			end
			default: state_d = md5d_pkg::S_ABSORB;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5d_pkg::S_ABSORB;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			len_q       <= '0;
			two_blk_q   <= 1'b0;
			out_valid_q <= 1'b0;
			part_q      <= 1'b0;
		end else begin
			if (accept && msg.kind == md5d_pkg::KIND_BYTE) begin
				fill_q <= fill_q + 6'd1;
				len_q  <= len_q + 64'd8;
			end
			if (accept && msg.kind == md5d_pkg::KIND_FINISH) begin
				two_blk_q <= (fill_q >= md5d_pkg::TAIL_LIMIT);
			end
			if (capture) begin
				fill_q      <= '0;
				len_q       <= '0;
				out_valid_q <= 1'b1;
				part_q      <= 1'b0;
			end else if (out_valid_q && !dig_stall) begin
				if (part_q) begin
					out_valid_q <= 1'b0;
				end
				part_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= merged;
		end
		if (capture) begin
			digest_q <= {bswap(stat.chain_a), bswap(stat.chain_b),
				bswap(stat.chain_c), bswap(stat.chain_d)};
		end
	end

	assign dig_valid       = out_valid_q;
	assign dig.digest_part = part_q ? digest_q[63:0] : digest_q[127:64];
	assign dig.part_index  = part_q;
	assign dig.last_part   = part_q;

`ifndef NO_ASSERTIONS
	a_finish_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall && msg.kind == md5d_pkg::KIND_FINISH) |=> msg_stall)
		else $error("byte beat taken right after a finish beat");
	a_capture_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == md5d_pkg::S_EMIT && !dig_valid) |=> (dig_valid && !dig.part_index))
		else $error("digest not presented after the final block");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && dig.last_part) |=> !dig_valid)
		else $error("digest output still valid after its last beat");
`endif

endmodule
